// ===== rtl/peaking_eq_coefficient_calc_macros.svh =====
// assertion macros shared by the rtl
`ifndef PEAKING_EQ_COEFFICIENT_CALC_MACROS_SVH
`define PEAKING_EQ_COEFFICIENT_CALC_MACROS_SVH

`ifndef ASSERT_OFF
`define PEC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PEC_ASSERT_NOW(lbl, ante, cons, msg)
`define PEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/pec_pkg.sv =====
`timescale 1ns / 1ps
package pec_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;
	localparam logic [17:0] SAMPLE_RATE_RESET = 18'd48000;

	localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [29:0] LOG2_10_DIV20_Q32 = 30'd713378626;
	localparam logic [30:0] R_CLAMP = 31'h7F00_0000;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	localparam int unsigned TRIG_STEPS = 6;
	localparam int unsigned EXP_STEPS = 12;

	typedef enum logic [1:0] {
		LANE_SIN,
		LANE_COS,
		LANE_EXP
	} lane_kind_t;

	// sign and saturation of the four distinct quotients
	typedef struct packed {
		logic [3:0] neg;
		logic [3:0] sat;
	} qd_side_t;

	function automatic int unsigned horner_div(lane_kind_t kind, int unsigned step);
		int unsigned d;
		d = 1;
		case (kind)
			LANE_SIN: begin
				case (step)
					0: d = 156;
					1: d = 110;
					2: d = 72;
					3: d = 42;
					4: d = 20;
					default: d = 6;
				endcase
			end
			LANE_COS: begin
				case (step)
					0: d = 132;
					1: d = 90;
					2: d = 56;
					3: d = 30;
					4: d = 12;
					default: d = 2;
				endcase
			end
			default: d = EXP_STEPS - step;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/pec_delay.sv =====
`timescale 1ns / 1ps
module pec_delay #(
	parameter int unsigned W = 1,
	parameter int unsigned N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] line_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= din;
			for (int i = 1; i < N; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign dout = line_s[N-1];

endmodule

// ===== rtl/pec_udiv.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage; num >> QW must be below den
module pec_udiv #(
	parameter int unsigned NUM_W = 49,
	parameter int unsigned DEN_W = 18,
	parameter int unsigned QW = 31
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QW-1:0]    quo
);

	logic [DEN_W-1:0] rem_s [QW];
	logic [DEN_W-1:0] den_s [QW];
	logic [QW-1:0]    low_s [QW];
	logic [QW-1:0]    quo_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QW-1:0]    low_in;
		logic [QW-1:0]    quo_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in = DEN_W'(num[NUM_W-1:QW]);
			assign den_in = den;
			assign low_in = num[QW-1:0];
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign low_in = low_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, low_in[QW-1]};
		assign ge = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				den_s[i] <= den_in;
				low_s[i] <= {low_in[QW-2:0], 1'b0};
				quo_s[i] <= {quo_in[QW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

// ===== rtl/pec_cdiv.sv =====
`timescale 1ns / 1ps
// divide by a small constant: reciprocal estimate, then one correction
module pec_cdiv #(
	parameter int unsigned DIV = 3
) (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] x,
	output logic [31:0] q
);

	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIV);
	localparam logic [7:0] DIV_V = 8'(DIV);

	logic [64:0] prod_s1;
	logic [31:0] x_s1;
	logic [31:0] q0;
	logic [39:0] back;
	logic [31:0] rem;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= x * RECIP;
			x_s1 <= x;
		end
	end

	// estimate is exact or one low
	assign q0 = prod_s1[63:32];
	assign back = q0 * DIV_V;
	assign rem = x_s1 - back[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			q <= (rem >= 32'(DIV_V)) ? q0 + 32'd1 : q0;
		end
	end

endmodule

// ===== rtl/pec_horner.sv =====
`timescale 1ns / 1ps
// truncated series in horner form, three stages per term plus an output stage
module pec_horner #(
	parameter pec_pkg::lane_kind_t KIND = pec_pkg::LANE_SIN,
	parameter int unsigned STEPS = 6
) (
	input  logic        clk,
	input  logic        en,
	input  logic [29:0] x,
	output logic [31:0] t
);

	logic [31:0] m_s1  [STEPS];
	logic [29:0] xa_s1 [STEPS];
	logic [29:0] xb_s2 [STEPS];
	logic [29:0] xc_s3 [STEPS];
	logic [31:0] q_s3  [STEPS];
	logic [31:0] t_next [STEPS];
	logic [31:0] t_out_q;

	for (genvar j = 0; j < STEPS; j++) begin : g_term
		logic [29:0] x_in;
		logic [31:0] t_in;
		logic [61:0] prod;

		if (j == 0) begin : g_first
			assign x_in = x;
			assign t_in = pec_pkg::ONE_Q30;
		end else begin : g_next
			assign x_in = xc_s3[j-1];
			assign t_in = t_next[j-1];
		end

		assign prod = x_in * t_in;

		always_ff @(posedge clk) begin
			if (en) begin
				m_s1[j] <= prod[61:30];
				xa_s1[j] <= x_in;
				xb_s2[j] <= xa_s1[j];
				xc_s3[j] <= xb_s2[j];
			end
		end

		pec_cdiv #(
			.DIV(pec_pkg::horner_div(KIND, j))
		) u_cdiv (
			.clk(clk),
			.en (en),
			.x  (m_s1[j]),
			.q  (q_s3[j])
		);

		if (KIND == pec_pkg::LANE_EXP) begin : g_add
			assign t_next[j] = pec_pkg::ONE_Q30 + q_s3[j];
		end else begin : g_sub
			assign t_next[j] = pec_pkg::ONE_Q30 - q_s3[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_out_q <= t_next[STEPS-1];
		end
	end

	assign t = t_out_q;

endmodule

// ===== rtl/peaking_eq_coefficient_calc.sv =====
`timescale 1ns / 1ps
`include "peaking_eq_coefficient_calc_macros.svh"
// Constant-Q peaking EQ coefficient calculator. Each request (centre frequency, Q in Q4.12,
// gain in Q6.8 dB) yields the five biquad coefficients in signed Q7.24 and a range flag,
// set when the frequency was clamped below Nyquist or a coefficient saturated. The block
// is one pipeline of 139 register stages: a request is taken in every cycle in which req_stall
// is low, and all stages advance together. The depth comes from the restoring dividers,
// which retire one quotient bit per stage (31 stages for fc/fs, 48 for the division by Q,
// 31 for the coefficient quotients), and from the sine/cosine series at three stages a term.
// While a result waits under res_stall the whole pipeline holds and req_stall is raised.
// sample_rate_hz sits at address 0 and must only be written while the pipeline is empty.
module peaking_eq_coefficient_calc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pec_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [16:0]                centre_freq_hz,
	input  logic [15:0]                quality_q12,
	input  logic signed [13:0]         gain_db_q8,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic signed [31:0]         ff_coef0,
	output logic signed [31:0]         ff_coef1,
	output logic signed [31:0]         ff_coef2,
	output logic signed [31:0]         fb_coef1,
	output logic signed [31:0]         fb_coef2,
	output logic                       range_flag
);

	localparam int unsigned L_TRIG = 3 * pec_pkg::TRIG_STEPS + 1;
	localparam int unsigned L_EXP = 3 * pec_pkg::EXP_STEPS + 1;
	localparam int unsigned FREQ_QW = 31;
	localparam int unsigned QDIV_QW = 48;
	localparam int unsigned COEF_QW = 31;

	localparam int unsigned T_R = FREQ_QW;
	localparam int unsigned T_P1 = T_R + 1;
	localparam int unsigned T_P2 = T_P1 + 1;
	localparam int unsigned T_U2 = T_P2 + 1;
	localparam int unsigned T_HSC = T_U2 + L_TRIG;
	localparam int unsigned T_SC = T_HSC + 1;
	localparam int unsigned T_SQ = T_SC + 1;
	localparam int unsigned T_BX = T_SQ + 1;
	localparam int unsigned T_AB = T_BX + QDIV_QW;
	localparam int unsigned T_SUM = T_AB + 1;
	localparam int unsigned T_MAG = T_SUM + 1;
	localparam int unsigned T_QD = T_MAG + COEF_QW;
	localparam int unsigned T_OUT = T_QD + 1;
	localparam int unsigned T_E1 = 1;
	localparam int unsigned T_Y = T_E1 + 1;
	localparam int unsigned T_T = T_Y + L_EXP;
	localparam int unsigned T_W = T_T + 1;

	// configuration
	logic [17:0] sample_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= pec_pkg::SAMPLE_RATE_RESET;
		end else if (psel && penable && pwrite && paddr[2:2] == pec_pkg::REG_SAMPLE_RATE) begin
			sample_rate_q <= pwdata[17:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == pec_pkg::REG_SAMPLE_RATE) ? {14'd0, sample_rate_q} : 32'd0;

	// pipeline control: every stage moves together
	logic adv;
	logic vld_s [T_OUT+1];

	assign adv = !res_valid || !res_stall;
	assign req_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= T_OUT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= req_valid;
			for (int i = 1; i <= T_OUT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign res_valid = vld_s[T_OUT];

	// input stage
	logic [13:0] graw;
	logic        boost_in;
	logic [16:0] fc_s0;
	logic [15:0] q_s0;
	logic [13:0] gmag_s0;
	logic        boost_s0;
	logic        clamp_s0;

	assign graw = gain_db_q8;
	assign boost_in = !graw[13];

	always_ff @(posedge clk) begin
		if (adv) begin
			fc_s0 <= centre_freq_hz;
			q_s0 <= (quality_q12 == 16'd0) ? 16'd1 : quality_q12;
			gmag_s0 <= boost_in ? graw : ~graw + 14'd1;
			boost_s0 <= boost_in;
			clamp_s0 <= (sample_rate_q == 18'd0) || ({centre_freq_hz, 1'b0} >= sample_rate_q);
		end
	end

	// frequency ratio fc / fs in q0.32
	logic [30:0] r_quo;
	logic        clamp_r;

	pec_udiv #(.NUM_W(49), .DEN_W(18), .QW(FREQ_QW)) u_fdiv (
		.clk(clk), .en(adv), .num({fc_s0, 32'd0}), .den(sample_rate_q), .quo(r_quo)
	);

	pec_delay #(.W(1), .N(T_R)) u_clamp_dly (
		.clk(clk), .en(adv), .din(clamp_s0), .dout(clamp_r)
	);

	// gain lane: w = 10^(|gain|/20)
	logic [43:0] eprod;
	logic [33:0] e_s1;
	logic [59:0] yprod;
	logic [29:0] y_s2;
	logic [2:0]  sh_t;
	logic [31:0] t_exp;
	logic [38:0] w_full;
	logic [29:0] w24_s40;

	assign eprod = gmag_s0 * pec_pkg::LOG2_10_DIV20_Q32;
	assign yprod = e_s1[29:0] * pec_pkg::LN2_Q30;

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1 <= eprod[43:10];
			y_s2 <= yprod[59:30];
		end
	end

	pec_horner #(.KIND(pec_pkg::LANE_EXP), .STEPS(pec_pkg::EXP_STEPS)) u_exp (
		.clk(clk), .en(adv), .x(y_s2), .t(t_exp)
	);

	pec_delay #(.W(3), .N(T_T - T_E1)) u_sh_dly (
		.clk(clk), .en(adv), .din(e_s1[32:30]), .dout(sh_t)
	);

	assign w_full = 39'(t_exp) << sh_t;

	always_ff @(posedge clk) begin
		if (adv) begin
			w24_s40 <= w_full[35:6];
		end
	end

	// angle and reflection into the first octant
	logic [30:0] rsel;
	logic [30:0] v_s32;
	logic        refl_s32;
	logic [62:0] uprod_s33;
	logic [29:0] u;
	logic [59:0] u2prod;
	logic [29:0] u_s34;
	logic [29:0] u2_s34;

	assign rsel = clamp_r ? pec_pkg::R_CLAMP : r_quo;
	assign u = uprod_s33[61:32];
	assign u2prod = u * u;

	always_ff @(posedge clk) begin
		if (adv) begin
			refl_s32 <= rsel[30];
			v_s32 <= rsel[30] ? 31'(32'h8000_0000 - {1'b0, rsel}) : rsel;
			uprod_s33 <= v_s32 * pec_pkg::PI_Q30;
			u_s34 <= u;
			u2_s34 <= u2prod[59:30];
		end
	end

	// sine and cosine lanes
	logic [31:0] t_sin;
	logic [31:0] t_cos;
	logic [29:0] u_h;
	logic [31:0] cos_h;
	logic        refl_h;
	logic [61:0] sprod;
	logic [30:0] sin_s54;

	pec_horner #(.KIND(pec_pkg::LANE_SIN), .STEPS(pec_pkg::TRIG_STEPS)) u_sin (
		.clk(clk), .en(adv), .x(u2_s34), .t(t_sin)
	);

	pec_horner #(.KIND(pec_pkg::LANE_COS), .STEPS(pec_pkg::TRIG_STEPS)) u_cos (
		.clk(clk), .en(adv), .x(u2_s34), .t(t_cos)
	);

	pec_delay #(.W(30), .N(T_HSC - T_U2)) u_u_dly (
		.clk(clk), .en(adv), .din(u_s34), .dout(u_h)
	);

	pec_delay #(.W(32), .N(T_SC - T_HSC)) u_cos_dly (
		.clk(clk), .en(adv), .din(t_cos), .dout(cos_h)
	);

	pec_delay #(.W(1), .N(T_SC - T_P1)) u_refl_dly (
		.clk(clk), .en(adv), .din(refl_s32), .dout(refl_h)
	);

	assign sprod = u_h * t_sin;

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_s54 <= sprod[60:30];
		end
	end

	// squares and cross product
	logic [30:0] s_sw;
	logic [30:0] c_sw;
	logic [61:0] c2prod;
	logic [61:0] s2prod;
	logic [61:0] scprod;
	logic [30:0] c2_s55;
	logic [30:0] s2_s55;
	logic [30:0] sc_s55;

	assign s_sw = refl_h ? cos_h[30:0] : sin_s54;
	assign c_sw = refl_h ? sin_s54 : cos_h[30:0];
	assign c2prod = c_sw * c_sw;
	assign s2prod = s_sw * s_sw;
	assign scprod = s_sw * c_sw;

	always_ff @(posedge clk) begin
		if (adv) begin
			c2_s55 <= c2prod[60:30];
			s2_s55 <= s2prod[60:30];
			sc_s55 <= scprod[60:30];
		end
	end

	// base, beta and the numerators of the division by q
	logic [29:0] w24_h;
	logic [60:0] bprod;
	logic [33:0] diff;
	logic [48:0] anum_s56;
	logic [48:0] bnum_s56;
	logic [31:0] base_s56;
	logic [33:0] beta_s56;
	logic [15:0] q_h;

	pec_delay #(.W(30), .N(T_SQ - T_W)) u_w_dly (
		.clk(clk), .en(adv), .din(w24_s40), .dout(w24_h)
	);

	pec_delay #(.W(16), .N(T_BX)) u_q_dly (
		.clk(clk), .en(adv), .din(q_s0), .dout(q_h)
	);

	assign bprod = sc_s55 * w24_h;
	assign diff = {3'd0, s2_s55} - {3'd0, c2_s55};

	always_ff @(posedge clk) begin
		if (adv) begin
			anum_s56 <= 49'({sc_s55, 12'd0});
			bnum_s56 <= {1'b0, bprod[59:24], 12'd0};
			base_s56 <= 32'(c2_s55) + 32'(s2_s55);
			beta_s56 <= {diff[32:0], 1'b0};
		end
	end

	logic [47:0] a_quo;
	logic [47:0] b_quo;
	logic [31:0] base_h;
	logic [33:0] beta_h;
	logic        boost_h;

	pec_udiv #(.NUM_W(49), .DEN_W(16), .QW(QDIV_QW)) u_adiv (
		.clk(clk), .en(adv), .num(anum_s56), .den(q_h), .quo(a_quo)
	);

	pec_udiv #(.NUM_W(49), .DEN_W(16), .QW(QDIV_QW)) u_bdiv (
		.clk(clk), .en(adv), .num(bnum_s56), .den(q_h), .quo(b_quo)
	);

	pec_delay #(.W(66), .N(T_AB - T_BX)) u_bb_dly (
		.clk(clk), .en(adv), .din({base_s56, beta_s56}), .dout({base_h, beta_h})
	);

	pec_delay #(.W(1), .N(T_AB)) u_boost_dly (
		.clk(clk), .en(adv), .din(boost_s0), .dout(boost_h)
	);

	// numerators and denominator of the coefficients
	logic [47:0] pterm;
	logic [47:0] dterm;
	logic [49:0] num_s105 [4];
	logic [48:0] den_s105;

	assign pterm = boost_h ? b_quo : a_quo;
	assign dterm = boost_h ? a_quo : b_quo;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s105 <= 49'(base_h) + 49'(dterm);
			num_s105[0] <= 50'(base_h) + 50'(pterm);
			num_s105[1] <= {{16{beta_h[33]}}, beta_h};
			num_s105[2] <= 50'(base_h) - 50'(pterm);
			num_s105[3] <= 50'(base_h) - 50'(dterm);
		end
	end

	// magnitude, sign and saturation test
	logic [48:0]       mag_s106 [4];
	logic [48:0]       den_s106;
	pec_pkg::qd_side_t side_s106;

	for (genvar k = 0; k < 4; k++) begin : g_mag
		logic        neg;
		logic [49:0] negv;
		logic [48:0] mag;

		assign neg = num_s105[k][49];
		assign negv = 50'd0 - num_s105[k];
		assign mag = neg ? negv[48:0] : num_s105[k][48:0];

		always_ff @(posedge clk) begin
			if (adv) begin
				mag_s106[k] <= mag;
				side_s106.neg[k] <= neg;
				side_s106.sat[k] <= {7'd0, mag} >= {den_s105, 7'd0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s106 <= den_s105;
		end
	end

	// coefficient quotients to 24 fraction bits
	logic [30:0]       cq [4];
	pec_pkg::qd_side_t side_h;
	logic              clamp_h;

	for (genvar k = 0; k < 4; k++) begin : g_qdiv
		pec_udiv #(.NUM_W(73), .DEN_W(49), .QW(COEF_QW)) u_qdiv (
			.clk(clk), .en(adv), .num({mag_s106[k], 24'd0}), .den(den_s106), .quo(cq[k])
		);
	end

	pec_delay #(.W($bits(pec_pkg::qd_side_t)), .N(T_QD - T_MAG)) u_side_dly (
		.clk(clk), .en(adv), .din(side_s106), .dout(side_h)
	);

	pec_delay #(.W(1), .N(T_QD)) u_flag_dly (
		.clk(clk), .en(adv), .din(clamp_s0), .dout(clamp_h)
	);

	// sign, saturation and result register
	logic [31:0] coef_s138 [4];
	logic        flag_s138;

	for (genvar k = 0; k < 4; k++) begin : g_out
		logic [31:0] pos;
		logic [31:0] val;

		assign pos = {1'b0, cq[k]};

		always_comb begin
			if (side_h.sat[k]) begin
				val = side_h.neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				val = side_h.neg[k] ? 32'd0 - pos : pos;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				coef_s138[k] <= val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s138 <= clamp_h || (side_h.sat != 4'd0);
		end
	end

	// beta feeds both middle coefficients
	assign ff_coef0 = coef_s138[0];
	assign ff_coef1 = coef_s138[1];
	assign ff_coef2 = coef_s138[2];
	assign fb_coef1 = coef_s138[1];
	assign fb_coef2 = coef_s138[3];
	assign range_flag = flag_s138;

	`PEC_ASSERT_NOW(a_stall_holds_input, res_valid && res_stall, req_stall, "pipeline not held")
	`PEC_ASSERT_NEXT(a_result_arrives, vld_s[T_OUT-1] && !req_stall, res_valid, "result lost")
	`PEC_ASSERT_NEXT(a_no_phantom, res_valid && !res_stall && !vld_s[T_OUT-1], !res_valid,
		"result repeated")

endmodule
